@@ hw/rtl/cdt_pkg.sv @@
`timescale 1ns / 1ps

package cdt_pkg;

	localparam int COUNTER_BITS_DEFAULT = 29;
	localparam int DATA_W = 32;
	localparam int USEC_W = 32;
	localparam int PRESCALE_W = 8;

	localparam int ENABLE_BIT = 31;
	localparam int MODE_BIT = 30;

	localparam logic [PRESCALE_W-1:0] USEC_CFG_RESET = 8'hb;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [1:0] REG_TRIGGER = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;
	localparam logic [1:0] REG_USEC = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] reg_select;
		logic [DATA_W-1:0] write_data;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic irq_line;
	} result_t;

endpackage

@@ hw/rtl/cdt_core.sv @@
`timescale 1ns / 1ps

module cdt_core #(
	parameter int COUNTER_BITS = cdt_pkg::COUNTER_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic exec,
	input  cdt_pkg::item_t item,
	input  logic cfg_we,
	input  logic [cdt_pkg::PRESCALE_W-1:0] cfg_data,
	output cdt_pkg::result_t result
);
	import cdt_pkg::*;

	logic [PRESCALE_W-1:0] tpu_q;
	logic [COUNTER_BITS-1:0] reload_q;
	logic enable_q;
	logic periodic_q;
	logic [COUNTER_BITS-1:0] down_q;
	logic irq_q;
	logic [PRESCALE_W-1:0] prescale_q;
	logic [USEC_W-1:0] usec_q;

	logic [COUNTER_BITS-1:0] reload_d;
	logic enable_d;
	logic periodic_d;
	logic [COUNTER_BITS-1:0] down_d;
	logic irq_d;
	logic [PRESCALE_W-1:0] prescale_d;
	logic [USEC_W-1:0] usec_d;
	logic [DATA_W-1:0] rd;

	always_comb begin
		reload_d = reload_q;
		enable_d = enable_q;
		periodic_d = periodic_q;
		down_d = down_q;
		irq_d = irq_q;
		prescale_d = prescale_q;
		usec_d = usec_q;
		rd = '0;
		unique case (item.kind)
			KIND_TICK: begin
				if (prescale_q >= tpu_q) begin
					prescale_d = '0;
					usec_d = usec_q + USEC_W'(1);
				end else begin
					prescale_d = prescale_q + PRESCALE_W'(1);
				end
				if (enable_q) begin
					if (down_q == '0) begin
						irq_d = 1'b1;
						if (periodic_q) begin
							down_d = reload_q;
						end else begin
							enable_d = 1'b0;
						end
					end else begin
						down_d = down_q - COUNTER_BITS'(1);
					end
				end
			end
			KIND_READ: begin
				unique case (item.reg_select)
					REG_TRIGGER: begin
						rd = DATA_W'(reload_q);
						rd[ENABLE_BIT] = enable_q;
						rd[MODE_BIT] = periodic_q;
					end
					REG_COUNT: begin
						rd = DATA_W'(down_q);
						rd[MODE_BIT] = irq_q;
					end
					REG_USEC: rd = usec_q;
					default: rd = '0;
				endcase
			end
			KIND_WRITE: begin
				if (item.reg_select == REG_TRIGGER) begin
					reload_d = item.write_data[COUNTER_BITS-1:0];
					enable_d = item.write_data[ENABLE_BIT];
					periodic_d = item.write_data[MODE_BIT];
					if (item.write_data[ENABLE_BIT]) begin
						down_d = item.write_data[COUNTER_BITS-1:0];
					end
				end else if (item.reg_select == REG_COUNT) begin
					if (item.write_data[MODE_BIT]) begin
						irq_d = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign result.read_data = rd;
	assign result.irq_line = irq_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= USEC_CFG_RESET;
		end else if (cfg_we) begin
			tpu_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= '0;
			enable_q <= 1'b0;
			periodic_q <= 1'b0;
			down_q <= '0;
			irq_q <= 1'b0;
			prescale_q <= '0;
			usec_q <= '0;
		end else if (exec) begin
			reload_q <= reload_d;
			enable_q <= enable_d;
			periodic_q <= periodic_d;
			down_q <= down_d;
			irq_q <= irq_d;
			prescale_q <= prescale_d;
			usec_q <= usec_d;
		end
	end

endmodule

@@ hw/rtl/countdown_timer_with_reload.sv @@
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+-------------------------
// item     | item_valid/stall     | item (kind, reg_select, write_data)
// result   | result_valid/stall   | result (read_data, irq_line)
// cfg      | cfg_valid/ready      | cfg_data (ticks_per_usec_minus_one)
//
// One item per cycle sustained while result_stall is low.
// The item register feeds the timer state update and the result register.
// A result stall holds the result register; the item register still fills
// when empty, so item_stall rises only once both are occupied.
// Reset clears all timer state; the prescale setting resets to 11.
// cfg_ready is always high.

module countdown_timer_with_reload #(
	parameter int COUNTER_BITS = cdt_pkg::COUNTER_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  cdt_pkg::item_t item,
	output logic result_valid,
	input  logic result_stall,
	output cdt_pkg::result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [cdt_pkg::PRESCALE_W-1:0] cfg_data
);
	import cdt_pkg::*;

	logic valid_s1;
	item_t item_s1;
	logic valid_s2;
	result_t result_s2;
	result_t result_comb;
	logic adv;

	assign adv = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	cdt_core #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.exec(valid_s1 && adv),
		.item(item_s1),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.result(result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (valid_s1 && adv) begin
			result_s2 <= result_comb;
		end
	end

	assign result_valid = valid_s2;
	assign result = result_s2;

endmodule

@@ hw/rtl/cdt_checker.sv @@
`timescale 1ns / 1ps

module cdt_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input logic result_valid,
	input logic result_stall,
	input cdt_pkg::result_t result,
	input logic cfg_valid,
	input logic cfg_ready
);
	import cdt_pkg::*;

	// stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// input backpressure only when the output side is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item_stall without blocked result");

	// a fresh result comes from an accepted item that passed through the item register
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 2))
		else $error("result without accepted item");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write refused");

endmodule

bind countdown_timer_with_reload cdt_checker u_cdt_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import cdt_pkg::*;

	localparam int CB = COUNTER_BITS_DEFAULT;
	localparam int HOLD_LEN = 300;
	localparam int PHASE_ITEMS = 245;
	localparam int N_DIRECTED = 25;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] sel;
		logic [DATA_W-1:0] data;
		bit typed;
		logic [DATA_W-1:0] rd;
		logic irq;
	} directed_row_t;

	// typed rows carry their expected result; the rest go through the predictor
	localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{KIND_READ,  REG_TRIGGER, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{KIND_READ,  REG_COUNT,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{KIND_READ,  REG_USEC,    32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{KIND_READ,  2'd3,        32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		'{2'd3,       REG_TRIGGER, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		'{KIND_WRITE, 2'd3,        32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		'{KIND_WRITE, REG_USEC,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		'{KIND_WRITE, REG_TRIGGER, 32'hC000_0002, 1'b1, 32'h0000_0000, 1'b0},
		'{KIND_READ,  REG_TRIGGER, 32'h0000_0000, 1'b1, 32'hC000_0002, 1'b0},
		'{KIND_TICK,  REG_TRIGGER, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
		'{KIND_TICK,  REG_COUNT,   32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{KIND_TICK,  REG_TRIGGER, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
		'{KIND_READ,  REG_COUNT,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
		'{KIND_WRITE, REG_COUNT,   32'hBFFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{KIND_WRITE, REG_COUNT,   32'h4000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{KIND_WRITE, REG_TRIGGER, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{KIND_TICK,  REG_TRIGGER, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
		'{KIND_TICK,  REG_TRIGGER, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
		'{KIND_READ,  REG_TRIGGER, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
		'{KIND_WRITE, REG_TRIGGER, 32'h0000_0005, 1'b0, 32'h0, 1'b0},
		'{KIND_WRITE, REG_TRIGGER, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{KIND_READ,  REG_TRIGGER, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
		'{KIND_READ,  REG_COUNT,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
		'{KIND_TICK,  REG_USEC,    32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{KIND_READ,  REG_USEC,    32'h0000_0000, 1'b0, 32'h0, 1'b0}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [PRESCALE_W-1:0] cfg_data = '0;

	// predictor state
	logic [PRESCALE_W-1:0] usec_divider = USEC_CFG_RESET;
	logic [CB-1:0] trig_reload = '0;
	bit trig_enable = 1'b0;
	bit trig_periodic = 1'b0;
	logic [CB-1:0] remaining = '0;
	bit irq_flag = 1'b0;
	logic [PRESCALE_W-1:0] prescaler = '0;
	logic [USEC_W-1:0] usec_now = '0;

	result_t pending_results [$];
	result_t want;
	int mismatches = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_go = 1'b0;
	int hold_cycles = 0;

	countdown_timer_with_reload DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t advance_timer(item_t it);
		result_t r;
		r = '0;
		case (it.kind)
			KIND_TICK: begin
				if (prescaler >= usec_divider) begin
					prescaler = '0;
					usec_now = usec_now + USEC_W'(1);
				end else begin
					prescaler = prescaler + PRESCALE_W'(1);
				end
				if (trig_enable) begin
					if (remaining == '0) begin
						irq_flag = 1'b1;
						if (trig_periodic)
							remaining = trig_reload;
						else
							trig_enable = 1'b0;
					end else begin
						remaining = remaining - CB'(1);
					end
				end
			end
			KIND_READ: begin
				case (it.reg_select)
					REG_TRIGGER: begin
						r.read_data = DATA_W'(trig_reload);
						r.read_data[ENABLE_BIT] = trig_enable;
						r.read_data[MODE_BIT] = trig_periodic;
					end
					REG_COUNT: begin
						r.read_data = DATA_W'(remaining);
						r.read_data[MODE_BIT] = irq_flag;
					end
					REG_USEC: r.read_data = usec_now;
					default: r.read_data = '0;
				endcase
			end
			KIND_WRITE: begin
				if (it.reg_select == REG_TRIGGER) begin
					trig_reload = it.write_data[CB-1:0];
					trig_enable = it.write_data[ENABLE_BIT];
					trig_periodic = it.write_data[MODE_BIT];
					if (trig_enable)
						remaining = trig_reload;
				end else if (it.reg_select == REG_COUNT) begin
					if (it.write_data[MODE_BIT])
						irq_flag = 1'b0;
				end
			end
			default: ;
		endcase
		r.irq_line = irq_flag;
		return r;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int p;
		it.kind = 2'd3;
		it.reg_select = 2'($urandom_range(3));
		it.write_data = $urandom;
		p = $urandom_range(99);
		if (p < 55) begin
			it.kind = KIND_TICK;
		end else if (p < 72) begin
			it.kind = KIND_READ;
		end else if (p < 95) begin
			it.kind = KIND_WRITE;
			p = $urandom_range(99);
			if (p < 50) begin
				it.reg_select = REG_TRIGGER;
				if ($urandom_range(3) != 0) begin
					// short reload values so that expiry happens often
					it.write_data = '0;
					it.write_data[CB-1:0] = CB'($urandom_range(6));
					it.write_data[ENABLE_BIT] = ($urandom_range(5) != 0);
					it.write_data[MODE_BIT] = 1'($urandom_range(1));
					it.write_data[CB] = 1'($urandom_range(1));
				end
			end else if (p < 80) begin
				it.reg_select = REG_COUNT;
			end
		end
		return it;
	endfunction

	task automatic send_item(input item_t it, input bit typed, input result_t typed_result);
		result_t r;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		r = advance_timer(it);
		pending_results.push_back(typed ? typed_result : r);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_prescale(input logic [PRESCALE_W-1:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		usec_divider = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int idle, input int stall, input bit long_hold);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (long_hold && i == 20)
				hold_go = 1'b1;
			if (i == PHASE_ITEMS / 2)
				drain();
			send_item(random_item(), 1'b0, '0);
		end
	endtask

	// receiver: one long hold-off, otherwise random stall
	always @(posedge clk) begin
		if (hold_go && hold_cycles < HOLD_LEN) begin
			hold_cycles <= hold_cycles + 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected transaction: read_data %h irq_line %b",
					result.read_data, result.irq_line);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (result.read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, result.read_data);
					mismatches++;
				end
				if (result.irq_line !== want.irq_line) begin
					$error("irq_line: expected %b, got %b", want.irq_line, result.irq_line);
					mismatches++;
				end
			end
		end
	end

	initial begin
		item_t it;
		result_t typed_result;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			it.kind = DIRECTED_ROWS[i].kind;
			it.reg_select = DIRECTED_ROWS[i].sel;
			it.write_data = DIRECTED_ROWS[i].data;
			typed_result.read_data = DIRECTED_ROWS[i].rd;
			typed_result.irq_line = DIRECTED_ROWS[i].irq;
			send_item(it, DIRECTED_ROWS[i].typed, typed_result);
		end

		write_prescale(8'd255);
		run_phase(0, 0, 1'b1);
		write_prescale(8'd0);
		run_phase(46, 0, 1'b0);
		write_prescale(PRESCALE_W'($urandom_range(1, 254)));
		run_phase(0, 46, 1'b0);
		write_prescale(8'd3);
		run_phase(17, 17, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#3ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/cdt_pkg.sv
hw/rtl/cdt_core.sv
hw/rtl/countdown_timer_with_reload.sv
hw/rtl/cdt_checker.sv
tb/testbench.sv
